### sv/ipb_pkg.sv
// Shared constants, codes and types for the I/O port permission bitmap.
package ipb_pkg;

  localparam int PORT_COUNT = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = PORT_COUNT / WORD_BITS;
  localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int SPAN_W     = 17;

  localparam logic [SPAN_W-1:0] PORT_LIMIT = SPAN_W'(PORT_COUNT);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOPERM  = 2'd2;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_RESP
  } state_t;

  // Span of one update: first and last bitmap word, bit bounds inside them.
  typedef struct packed {
    logic [WIDX_W-1:0] start_word;
    logic [WIDX_W-1:0] last_word;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
  } span_t;

endpackage

### sv/io_port_permission_bitmap.sv
// Top level of the I/O port permission bitmap: request sequencer and bitmap memory.
//
// Keeps one deny bit per I/O port (1 = denied), PORT_COUNT ports packed in
// NUM_WORDS words of WORD_BITS bits in a single-port-write, one-read
// synchronous memory; after reset every port is denied (per-word valid bits
// make an unwritten word read as all ones, so no clearing pass is needed).
// A check reads its word at acceptance, tests the port's bit in S_CHECK and
// loads the result register from S_RESP once the output register is free. An
// update walks the bitmap words its span touches, from the first to the last,
// reading the next word while it writes back the current one, one word per
// cycle through the memory port, then loads the result from S_RESP. Rejected
// requests (empty, wrapping or over-range span, unprivileged grant,
// out-of-range check) go straight from acceptance to S_RESP and leave the
// bitmap untouched.
// One request is in flight at a time; a new word is taken while the previous
// result still waits in the output register.
module io_port_permission_bitmap import ipb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] first_port, [31:16] port_count, [32] grant, [33] privileged, rest zero
  input  logic [39:0] in_tdata,
  // [0] op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [2] port_allowed, rest zero
  output logic [7:0]  out_tdata
);

  // Bitmap memory and its per-word written marks.
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_valid_r;

  state_t state_r, state_nxt;

  logic [WIDX_W-1:0] w_r;
  span_t             span_r;
  logic              deny_r;
  logic [1:0]        status_r;
  logic              allowed_r;
  logic              out_valid_r;
  logic [7:0]        out_tdata_r;

  // Request fields.
  logic              in_op;
  logic [15:0]       in_first;
  logic [15:0]       in_count;
  logic              in_grant;
  logic              in_priv;
  logic              in_fire;

  logic [SPAN_W-1:0] span_end;
  logic [SPAN_W-1:0] span_endm1;
  logic              range_ok;
  logic              check_ok;
  logic [1:0]        req_status;
  logic              req_go;

  // Memory control.
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] mask;
  logic                 out_free;
  logic                 walk_done;

  assign in_op    = in_tuser;
  assign in_first = in_tdata[15:0];
  assign in_count = in_tdata[31:16];
  assign in_grant = in_tdata[32];
  assign in_priv  = in_tdata[33];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Decode: span bounds at 17 bits so the sum never wraps.
  assign span_end   = {1'b0, in_first} + {1'b0, in_count};
  assign span_endm1 = span_end - SPAN_W'(1);
  assign range_ok   = (in_count != 16'd0) && (span_end <= PORT_LIMIT);
  assign check_ok   = ({1'b0, in_first} < PORT_LIMIT);

  always_comb begin
    req_status = ST_OK;
    req_go     = 1'b0;
    if (in_op == OP_CHECK) begin
      if (check_ok) begin
        req_go = 1'b1;
      end else begin
        req_status = ST_INVALID;
      end
    end else begin
      if (!range_ok) begin
        req_status = ST_INVALID;
      end else if (in_grant && !in_priv) begin
        req_status = ST_NOPERM;
      end else begin
        req_go = 1'b1;
      end
    end
  end

  // Unwritten words read as all denied.
  assign cur_word  = rd_valid_r ? rd_data_r : '1;
  assign out_free  = !out_valid_r || out_tready;
  assign walk_done = (w_r == span_r.last_word);

  ipb_mask u_mask (
    .word_idx (w_r),
    .span     (span_r),
    .mask     (mask)
  );

  assign wr_data = deny_r ? (cur_word | mask) : (cur_word & ~mask);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!req_go) begin
            state_nxt = S_RESP;
          end else if (in_op == OP_CHECK) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_CHECK: state_nxt = S_RESP;
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port control: read the first word at acceptance, then in the walk
  // write back the current word while reading the next one.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = w_r + WIDX_W'(1);
    wr_en   = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_en   = in_fire && req_go;
        rd_addr = in_first[BIT_W +: WIDX_W];
      end
      S_WALK: begin
        wr_en = 1'b1;
        rd_en = !walk_done;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Memory array and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[w_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
      if (wr_en) begin
        valid_r[w_r] <= 1'b1;
      end
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r               <= in_first[BIT_W +: WIDX_W];
      span_r.start_word <= in_first[BIT_W +: WIDX_W];
      span_r.last_word  <= span_endm1[BIT_W +: WIDX_W];
      span_r.lo_bit     <= in_first[BIT_W-1:0];
      span_r.hi_bit     <= span_endm1[BIT_W-1:0];
      deny_r            <= !in_grant;
      status_r          <= req_status;
      allowed_r         <= 1'b0;
    end else if (state_r == S_CHECK) begin
      allowed_r <= !cur_word[span_r.lo_bit];
    end else if (state_r == S_WALK && !walk_done) begin
      w_r <= w_r + WIDX_W'(1);
    end
  end

  // Output register: load the result, hold it until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free) begin
      out_tdata_r <= {5'd0, allowed_r, status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sv/ipb_mask.sv
// Bit mask of the update span that falls into one bitmap word.
module ipb_mask import ipb_pkg::*; (
  input  logic [WIDX_W-1:0]    word_idx,
  input  span_t                span,
  output logic [WORD_BITS-1:0] mask
);

  logic [BIT_W-1:0] lo;
  logic [BIT_W-1:0] hi;

  // Head word starts at the first bit, tail word stops at the last one.
  assign lo = (word_idx == span.start_word) ? span.lo_bit : '0;
  assign hi = (word_idx == span.last_word)  ? span.hi_bit : BIT_W'(WORD_BITS - 1);

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (BIT_W'(i) >= lo) && (BIT_W'(i) <= hi);
    end
  end

endmodule
